// ===== hdl/oahp_pkg.sv =====
// shared types, constants and lookup functions for the heading controller
package oahp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int UP_SHIFT   = 30 - FRAC_BITS;
   localparam int BEAM_COUNT = 5;
   localparam int BEAM_IDX_W = 3;
   localparam int RANGE_W    = 22;
   localparam int WEIGHT_W   = 12;
   localparam int CW         = 52;   // cordic x/y datapath
   localparam int ZW         = 36;   // cordic angle datapath, q6.30
   localparam int MW         = 33;   // multiplier operand width
   localparam int PW         = 2 * MW;
   localparam int ITER_COUNT = 30;

   localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [CW-1:0] Q30_CORDIC_K = 52'sd652032874;

   localparam longint AVOID_TURN_L =
      (-64'sd858993459 + (64'sd1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
   localparam longint AVOID_SPEED_L =
      (64'sd107374182 + (64'sd1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
   localparam longint TURN_LIMIT_L =
      (64'sd1610612736 + (64'sd1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;

   localparam logic signed [17:0] AVOID_TURN  = 18'(AVOID_TURN_L);
   localparam logic [19:0]        AVOID_SPEED = 20'(AVOID_SPEED_L);
   localparam logic signed [17:0] TURN_LIMIT  = 18'(TURN_LIMIT_L);

   typedef enum logic [2:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_CRUISE_SPEED = 3'd3,
      CSR_BEAM_WEIGHTS = 3'd4,
      CSR_MAX_RANGE    = 3'd5,
      CSR_NEAR_LIMIT   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic start;
      logic vec;     // 1 vectoring (atan2), 0 rotation (sin/cos)
   } cordic_cmd_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:  v = 36'sd843314857;
         5'd1:  v = 36'sd497837829;
         5'd2:  v = 36'sd263043837;
         5'd3:  v = 36'sd133525159;
         5'd4:  v = 36'sd67021687;
         5'd5:  v = 36'sd33543516;
         5'd6:  v = 36'sd16775851;
         5'd7:  v = 36'sd8388437;
         5'd8:  v = 36'sd4194283;
         5'd9:  v = 36'sd2097149;
         5'd10: v = 36'sd1048576;
         5'd11: v = 36'sd524288;
         5'd12: v = 36'sd262144;
         5'd13: v = 36'sd131072;
         5'd14: v = 36'sd65536;
         5'd15: v = 36'sd32768;
         5'd16: v = 36'sd16384;
         5'd17: v = 36'sd8192;
         5'd18: v = 36'sd4096;
         5'd19: v = 36'sd2048;
         5'd20: v = 36'sd1024;
         5'd21: v = 36'sd512;
         5'd22: v = 36'sd256;
         5'd23: v = 36'sd128;
         5'd24: v = 36'sd64;
         5'd25: v = 36'sd32;
         5'd26: v = 36'sd16;
         5'd27: v = 36'sd8;
         5'd28: v = 36'sd4;
         5'd29: v = 36'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [ZW-1:0] beam_angle(input logic [BEAM_IDX_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         3'd0:    v = -36'sd560029376;
         3'd1:    v = -36'sd279287765;
         3'd2:    v = 36'sd1454083;
         3'd3:    v = 36'sd282195457;
         3'd4:    v = 36'sd562937068;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/oahp_mul.sv =====
// registered signed multiplier shared by all products of the controller
module oahp_mul (
   input  logic                           clock,
   input  logic signed [oahp_pkg::MW-1:0] a_in,
   input  logic signed [oahp_pkg::MW-1:0] b_in,
   output logic signed [oahp_pkg::PW-1:0] p_ff
);

   always_ff @(posedge clock) begin
      p_ff <= oahp_pkg::PW'(a_in) * oahp_pkg::PW'(b_in);
   end

endmodule

// ===== hdl/oahp_cordic.sv =====
// iterative cordic, one micro-rotation per cycle, rotation and vectoring modes
module oahp_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  oahp_pkg::cordic_cmd_type       cmd,
   input  logic signed [oahp_pkg::CW-1:0] x_in,
   input  logic signed [oahp_pkg::CW-1:0] y_in,
   input  logic signed [oahp_pkg::ZW-1:0] z_in,
   output logic                           done_ff,
   output logic signed [oahp_pkg::CW-1:0] x_out,
   output logic signed [oahp_pkg::CW-1:0] y_out,
   output logic signed [oahp_pkg::ZW-1:0] z_out
);

   typedef enum logic [2:0] {
      C_IDLE, C_NORM_DN, C_NORM_UP, C_FLIP, C_ITER
   } cstate_type;

   localparam logic [oahp_pkg::CW-1:0] TOP = oahp_pkg::CW'(64'd1 << 40);
   localparam logic [oahp_pkg::CW-1:0] LOW = oahp_pkg::CW'(64'd1 << 39);

   cstate_type                     state_ff;
   logic signed [oahp_pkg::CW-1:0] x_ff, y_ff, sx, sy;
   logic signed [oahp_pkg::ZW-1:0] z_ff, at, z_fold;
   logic [oahp_pkg::CW-1:0]        mx, my;
   logic [4:0]                     i_ff;
   logic                           neg_ff, vec_ff, neg_in;

   always_comb begin
      sx = x_ff >>> i_ff;
      sy = y_ff >>> i_ff;
      at = oahp_pkg::atan_q30(i_ff);
      mx = x_ff[oahp_pkg::CW-1] ? oahp_pkg::CW'(-x_ff) : oahp_pkg::CW'(x_ff);
      my = y_ff[oahp_pkg::CW-1] ? oahp_pkg::CW'(-y_ff) : oahp_pkg::CW'(y_ff);
      // fold the angle into plus or minus half pi
      z_fold = z_in;
      neg_in = 1'b0;
      if (z_in > oahp_pkg::Q30_HALF_PI) begin
         z_fold = z_in - oahp_pkg::Q30_PI;
         neg_in = 1'b1;
      end else if (z_in < -oahp_pkg::Q30_HALF_PI) begin
         z_fold = z_in + oahp_pkg::Q30_PI;
         neg_in = 1'b1;
      end
   end

   assign x_out = neg_ff ? -x_ff : x_ff;
   assign y_out = neg_ff ? -y_ff : y_ff;
   assign z_out = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         i_ff     <= '0;
         neg_ff   <= 1'b0;
         vec_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (cmd.start) begin
                  vec_ff <= cmd.vec;
                  i_ff   <= '0;
                  if (cmd.vec) begin
                     x_ff     <= x_in;
                     y_ff     <= y_in;
                     z_ff     <= '0;
                     neg_ff   <= 1'b0;
                     state_ff <= C_NORM_DN;
                  end else begin
                     x_ff     <= oahp_pkg::Q30_CORDIC_K;
                     y_ff     <= '0;
                     z_ff     <= z_fold;
                     neg_ff   <= neg_in;
                     state_ff <= C_ITER;
                  end
               end
            end
            C_NORM_DN: begin
               if (mx >= TOP || my >= TOP) begin
                  x_ff <= x_ff >>> 1;
                  y_ff <= y_ff >>> 1;
               end else begin
                  state_ff <= C_NORM_UP;
               end
            end
            C_NORM_UP: begin
               if (mx < LOW && my < LOW) begin
                  x_ff <= x_ff <<< 1;
                  y_ff <= y_ff <<< 1;
               end else begin
                  state_ff <= C_FLIP;
               end
            end
            C_FLIP: begin
               if (x_ff < 0) begin
                  z_ff <= (y_ff >= 0) ? oahp_pkg::Q30_PI : -oahp_pkg::Q30_PI;
                  x_ff <= -x_ff;
                  y_ff <= -y_ff;
               end
               state_ff <= C_ITER;
            end
            C_ITER: begin
               if ((!vec_ff && z_ff >= 0) || (vec_ff && y_ff <= 0)) begin
                  // rotation with positive residue, or vectoring below axis
                  if (vec_ff) begin
                     x_ff <= x_ff - sy;
                     y_ff <= y_ff + sx;
                     z_ff <= z_ff - at;
                  end else begin
                     x_ff <= x_ff - sy;
                     y_ff <= y_ff + sx;
                     z_ff <= z_ff - at;
                  end
               end else begin
                  x_ff <= x_ff + sy;
                  y_ff <= y_ff - sx;
                  z_ff <= vec_ff ? z_ff + at : z_ff + at;
               end
               if (i_ff == 5'(oahp_pkg::ITER_COUNT - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end else begin
                  i_ff <= i_ff + 5'd1;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/obstacle_avoid_heading_pid_unit.sv =====
// top level: request decode, sequencer, state storage and pid step
// Obstacle-avoiding heading controller. A scan request (tuser 0) carries five
// beam ranges; each is rotated into the world frame with the stored pose and
// kept as an obstacle point, with no response. A pose request (tuser 1) gives
// one response: a fixed avoid turn when the stored centre beam is below
// near_limit, otherwise a pid turn toward the weighted avoidance vector at
// cruise_speed. All math runs on one iterative cordic (one micro-rotation a
// cycle, 30 per angle) and one registered 33x33 multiplier under a sequencer,
// and req_tready is low while a request is in work. A scan takes six cordic
// runs (heading, then each beam) plus 7 multiply steps per beam; a near
// obstacle pose request goes straight to the output state; any other pose
// request takes 13 multiplies, the cordic normalization shifts and
// iterations, and the pid steps, with the cordic skipped for a zero avoidance
// vector. A pose request may also wait in its output state for the response
// register to free up. A response waits in its output register while the
// next request is taken.
module obstacle_avoid_heading_pid_unit (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // beam_range_0..4 (22 each), beam_invalid (5), pos_x (32), pos_y (32),
   // heading (19), zero pad (2)
   input  logic [199:0] req_tdata,
   // mode
   input  logic [0:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // turn_rate (18), drive_speed (20), avoiding (1), zero pad (1)
   output logic [39:0]  rsp_tdata,
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [59:0]  csr_data
);

   localparam int RW  = oahp_pkg::RANGE_W;
   localparam int BC  = oahp_pkg::BEAM_COUNT;
   localparam int IW  = oahp_pkg::BEAM_IDX_W;
   localparam int MW  = oahp_pkg::MW;
   localparam int PW  = oahp_pkg::PW;
   localparam int CW  = oahp_pkg::CW;
   localparam int ZW  = oahp_pkg::ZW;
   localparam int FB  = oahp_pkg::FRAC_BITS;
   localparam int UP  = oahp_pkg::UP_SHIFT;
   localparam int CTR = BC / 2;

   typedef enum logic [4:0] {
      S_IDLE, S_SC_H, S_SC_HW, S_SC_B, S_SC_BW,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
      S_PX, S_PY, S_PN, S_VEC, S_VECW,
      S_WR1, S_WR2, S_INT, S_P0, S_P1, S_P2, S_P3, S_OUT
   } state_type;

   state_type state_ff;

   // registers
   logic signed [23:0]       prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [19:0]              cruise_speed_ff;
   logic [59:0]              beam_weights_ff;
   logic [RW-1:0]            max_range_ff, near_limit_ff;

   // controller state
   logic [RW-1:0]            beam_dist_ff;      // centre beam
   logic [31:0]              obs_x_ff [BC];
   logic [31:0]              obs_y_ff [BC];
   logic signed [31:0]       pose_x_ff, pose_y_ff, err_sum_ff;
   logic signed [18:0]       pose_hd_ff, prev_err_ff;

   // working registers
   logic [RW-1:0]            range_ff [BC];
   logic [IW-1:0]            idx_ff;
   logic signed [MW-1:0]     ch_ff, sh_ff, cb_ff, sb_ff, xo_ff, yo_ff;
   logic signed [PW-1:0]     acc_ff;
   logic signed [CW-1:0]     ux_ff, uy_ff;
   logic signed [ZW-1:0]     ang_ff;
   logic signed [18:0]       e_ff;
   logic signed [19:0]       ed_ff;
   logic signed [17:0]       res_turn_ff;
   logic                     res_avoid_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [39:0]              rsp_data_ff;

   // shared units
   logic signed [MW-1:0]     mul_a, mul_b;
   logic signed [PW-1:0]     mul_p;
   oahp_pkg::cordic_cmd_type ccmd;
   logic signed [ZW-1:0]     cz_in;
   logic                     cdone;
   logic signed [CW-1:0]     cx_out, cy_out;
   logic signed [ZW-1:0]     cz_out;

   // decode helpers
   logic [RW-1:0]            req_rng [BC];
   logic                     req_acc;
   logic signed [ZW-1:0]     hd_scaled;
   logic signed [32:0]       dx, dy, ei_sum;
   logic [11:0]              wt;
   logic signed [PW:0]       sum_m5, sum_m7;
   logic signed [PW:0]       w_sum;
   logic signed [PW-1:0]     w_rnd;

   oahp_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .p_ff  (mul_p)
   );

   oahp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ccmd),
      .x_in    (ux_ff),
      .y_in    (uy_ff),
      .z_in    (cz_in),
      .done_ff (cdone),
      .x_out   (cx_out),
      .y_out   (cy_out),
      .z_out   (cz_out)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < BC; i++) begin
         req_rng[i] = req_tdata[110 + i] ? max_range_ff : req_tdata[i*RW +: RW];
      end
      hd_scaled = ZW'(pose_hd_ff) <<< UP;
      dx  = 33'(signed'(obs_x_ff[idx_ff])) - 33'(pose_x_ff);
      dy  = 33'(signed'(obs_y_ff[idx_ff])) - 33'(pose_y_ff);
      wt  = beam_weights_ff[12*idx_ff +: 12];
      ei_sum = 33'(e_ff) + 33'(err_sum_ff);
      sum_m5 = (PW+1)'(acc_ff) - (PW+1)'(mul_p) + (PW+1)'(64'sd1 <<< 29);
      sum_m7 = (PW+1)'(acc_ff) + (PW+1)'(mul_p) + (PW+1)'(64'sd1 <<< 29);
      w_sum  = (PW+1)'(acc_ff) + (PW+1)'(mul_p) + (PW+1)'(64'sd1 <<< (FB - 1));
      w_rnd  = PW'(w_sum >>> FB);

      // a zero vector never starts the cordic, its normalization would not end
      ccmd.start = (state_ff == S_SC_H) || (state_ff == S_SC_B) ||
                   ((state_ff == S_VEC) && (ux_ff != '0 || uy_ff != '0));
      ccmd.vec   = (state_ff == S_VEC);
      cz_in      = (state_ff == S_SC_H) ? hd_scaled : oahp_pkg::beam_angle(idx_ff);

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M1: begin mul_a = MW'(range_ff[idx_ff]); mul_b = cb_ff; end
         S_M2: begin mul_a = MW'(range_ff[idx_ff]); mul_b = sb_ff; end
         S_M3: begin mul_a = xo_ff; mul_b = ch_ff; end
         S_M4: begin mul_a = yo_ff; mul_b = sh_ff; end
         S_M5: begin mul_a = xo_ff; mul_b = sh_ff; end
         S_M6: begin mul_a = yo_ff; mul_b = ch_ff; end
         S_PX: begin mul_a = dx; mul_b = MW'(wt); end
         S_PY: begin mul_a = dy; mul_b = MW'(wt); end
         S_P0: begin mul_a = MW'(e_ff); mul_b = MW'(prop_gain_ff); end
         S_P1: begin mul_a = MW'(err_sum_ff); mul_b = MW'(integ_gain_ff); end
         S_P2: begin mul_a = MW'(ed_ff); mul_b = MW'(deriv_gain_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         cruise_speed_ff <= '0;
         beam_weights_ff <= '0;
         max_range_ff    <= RW'(64'd1 << (FB + 4)) - RW'(64'd6 << FB);
         near_limit_ff   <= RW'(64'd1 << FB);
         beam_dist_ff    <= '0;
         for (int i = 0; i < BC; i++) begin
            obs_x_ff[i] <= '0;
            obs_y_ff[i] <= '0;
         end
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_hd_ff   <= '0;
         err_sum_ff   <= '0;
         prev_err_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output state sets the valid itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid) begin
            case (csr_index)
               oahp_pkg::CSR_PROP_GAIN:    prop_gain_ff    <= csr_data[23:0];
               oahp_pkg::CSR_INTEG_GAIN:   integ_gain_ff   <= csr_data[23:0];
               oahp_pkg::CSR_DERIV_GAIN:   deriv_gain_ff   <= csr_data[23:0];
               oahp_pkg::CSR_CRUISE_SPEED: cruise_speed_ff <= csr_data[19:0];
               oahp_pkg::CSR_BEAM_WEIGHTS: beam_weights_ff <= csr_data;
               oahp_pkg::CSR_MAX_RANGE:    max_range_ff    <= csr_data[RW-1:0];
               oahp_pkg::CSR_NEAR_LIMIT:   near_limit_ff   <= csr_data[RW-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  idx_ff <= '0;
                  if (!req_tuser[0]) begin
                     for (int i = 0; i < BC; i++) begin
                        range_ff[i] <= req_rng[i];
                     end
                     beam_dist_ff <= req_rng[CTR];
                     state_ff     <= S_SC_H;
                  end else if (beam_dist_ff < near_limit_ff) begin
                     res_turn_ff  <= oahp_pkg::AVOID_TURN;
                     res_avoid_ff <= 1'b1;
                     state_ff     <= S_OUT;
                  end else begin
                     pose_x_ff  <= req_tdata[146:115];
                     pose_y_ff  <= req_tdata[178:147];
                     pose_hd_ff <= req_tdata[197:179];
                     ux_ff      <= '0;
                     uy_ff      <= '0;
                     state_ff   <= S_PX;
                  end
               end
            end
            // scan: heading sin/cos, then per beam sin/cos and rotation
            S_SC_H:  state_ff <= S_SC_HW;
            S_SC_HW: begin
               if (cdone) begin
                  ch_ff    <= cx_out[MW-1:0];
                  sh_ff    <= cy_out[MW-1:0];
                  state_ff <= S_SC_B;
               end
            end
            S_SC_B:  state_ff <= S_SC_BW;
            S_SC_BW: begin
               if (cdone) begin
                  cb_ff    <= cx_out[MW-1:0];
                  sb_ff    <= cy_out[MW-1:0];
                  state_ff <= S_M1;
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: begin
               xo_ff    <= MW'((mul_p + PW'(64'sd1 <<< 29)) >>> 30);
               state_ff <= S_M3;
            end
            S_M3: begin
               yo_ff    <= MW'((mul_p + PW'(64'sd1 <<< 29)) >>> 30);
               state_ff <= S_M4;
            end
            S_M4: begin
               acc_ff   <= mul_p;
               state_ff <= S_M5;
            end
            S_M5: begin
               obs_x_ff[idx_ff] <= pose_x_ff + 32'(sum_m5 >>> 30);
               state_ff         <= S_M6;
            end
            S_M6: begin
               acc_ff   <= mul_p;
               state_ff <= S_M7;
            end
            S_M7: begin
               obs_y_ff[idx_ff] <= pose_y_ff + 32'(sum_m7 >>> 30);
               if (idx_ff == IW'(BC - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_SC_B;
               end
            end
            // pose: weighted avoidance vector
            S_PX: state_ff <= S_PY;
            S_PY: begin
               ux_ff    <= ux_ff + CW'(mul_p);
               state_ff <= S_PN;
            end
            S_PN: begin
               uy_ff <= uy_ff + CW'(mul_p);
               if (idx_ff == IW'(BC - 1)) begin
                  state_ff <= S_VEC;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_PX;
               end
            end
            S_VEC: begin
               // zero vector has heading zero, cordic is skipped
               if (ux_ff == '0 && uy_ff == '0) begin
                  ang_ff   <= -hd_scaled;
                  state_ff <= S_WR1;
               end else begin
                  state_ff <= S_VECW;
               end
            end
            S_VECW: begin
               if (cdone) begin
                  ang_ff   <= cz_out - hd_scaled;
                  state_ff <= S_WR1;
               end
            end
            S_WR1: begin
               if (ang_ff >= oahp_pkg::Q30_TWO_PI) begin
                  ang_ff <= ang_ff - oahp_pkg::Q30_TWO_PI;
               end else if (ang_ff <= -oahp_pkg::Q30_TWO_PI) begin
                  ang_ff <= ang_ff + oahp_pkg::Q30_TWO_PI;
               end
               state_ff <= S_WR2;
            end
            S_WR2: begin
               if (ang_ff > oahp_pkg::Q30_PI) begin
                  e_ff <= 19'((ang_ff - oahp_pkg::Q30_TWO_PI +
                               ZW'(64'sd1 <<< (UP - 1))) >>> UP);
               end else if (ang_ff <= -oahp_pkg::Q30_PI) begin
                  e_ff <= 19'((ang_ff + oahp_pkg::Q30_TWO_PI +
                               ZW'(64'sd1 <<< (UP - 1))) >>> UP);
               end else begin
                  e_ff <= 19'((ang_ff + ZW'(64'sd1 <<< (UP - 1))) >>> UP);
               end
               state_ff <= S_INT;
            end
            S_INT: begin
               // saturating integral, derivative against last error
               if (ei_sum > 33'sd2147483647) begin
                  err_sum_ff <= 32'sh7FFFFFFF;
               end else if (ei_sum < -33'sd2147483648) begin
                  err_sum_ff <= 32'sh80000000;
               end else begin
                  err_sum_ff <= ei_sum[31:0];
               end
               ed_ff       <= 20'(e_ff) - 20'(prev_err_ff);
               prev_err_ff <= e_ff;
               state_ff    <= S_P0;
            end
            S_P0: state_ff <= S_P1;
            S_P1: begin
               acc_ff   <= mul_p;
               state_ff <= S_P2;
            end
            S_P2: begin
               acc_ff   <= acc_ff + mul_p;
               state_ff <= S_P3;
            end
            S_P3: begin
               if (w_rnd > PW'(oahp_pkg::TURN_LIMIT)) begin
                  res_turn_ff <= oahp_pkg::TURN_LIMIT;
               end else if (w_rnd < -PW'(oahp_pkg::TURN_LIMIT)) begin
                  res_turn_ff <= -oahp_pkg::TURN_LIMIT;
               end else begin
                  res_turn_ff <= w_rnd[17:0];
               end
               res_avoid_ff <= 1'b0;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               // wait for the response register to free up
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, res_avoid_ff,
                                   res_avoid_ff ? oahp_pkg::AVOID_SPEED : cruise_speed_ff,
                                   res_turn_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
